// ===== rtl/nlc_pkg.sv =====
package nlc_pkg;

	typedef enum logic [3:0] {
		ST_START     = 4'd0,
		ST_SIGNED    = 4'd1,
		ST_ZERO      = 4'd2,
		ST_HEX       = 4'd3,
		ST_INTDIG    = 4'd4,
		ST_FRAC      = 4'd5,
		ST_EXP       = 4'd6,
		ST_EXPSIGN   = 4'd7,
		ST_EXPDIG    = 4'd8,
		ST_REJECT    = 4'd9,
		ST_END_NONE  = 4'd10,
		ST_END_INT   = 4'd11,
		ST_END_FLOAT = 4'd12
	} scan_state_t;

	typedef enum logic [1:0] {
		VERDICT_NONE  = 2'd0,
		VERDICT_INT   = 2'd1,
		VERDICT_FLOAT = 2'd2
	} verdict_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_code;
		logic       last;
	} item_t;

	function automatic logic is_dec(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE], [CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]};
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic verdict_t verdict_of(input scan_state_t st);
		verdict_t v;
		case (st)
			ST_ZERO, ST_HEX, ST_INTDIG, ST_END_INT: v = VERDICT_INT;
			ST_FRAC, ST_EXPDIG, ST_END_FLOAT:       v = VERDICT_FLOAT;
			default:                                v = VERDICT_NONE;
		endcase
		return v;
	endfunction

	function automatic scan_state_t advance(input scan_state_t st, input logic [7:0] c);
		scan_state_t nx;
		nx = ST_REJECT;
		if (st inside {ST_END_NONE, ST_END_INT, ST_END_FLOAT}) begin
			nx = st;
		end else if (c == CH_NUL) begin
			case (verdict_of(st))
				VERDICT_INT:   nx = ST_END_INT;
				VERDICT_FLOAT: nx = ST_END_FLOAT;
				default:       nx = ST_END_NONE;
			endcase
		end else begin
			case (st)
				ST_START, ST_SIGNED: begin
					if (st == ST_START && is_sign(c)) nx = ST_SIGNED;
					else if (c == CH_ZERO)            nx = ST_ZERO;
					else if (is_dec(c))               nx = ST_INTDIG;
					else                              nx = ST_REJECT;
				end
				ST_ZERO, ST_INTDIG: begin
					if (st == ST_ZERO && (c == CH_LC_X || c == CH_UC_X)) nx = ST_HEX;
					else if (is_dec(c))                                 nx = ST_INTDIG;
					else if (c == CH_POINT)                             nx = ST_FRAC;
					else                                                nx = ST_REJECT;
				end
				ST_HEX: begin
					nx = is_hex(c) ? ST_HEX : ST_REJECT;
				end
				ST_FRAC: begin
					if (is_dec(c))                          nx = ST_FRAC;
					else if (c == CH_LC_E || c == CH_UC_E)  nx = ST_EXP;
					else                                    nx = ST_REJECT;
				end
				ST_EXP, ST_EXPSIGN, ST_EXPDIG: begin
					if (st == ST_EXP && is_sign(c)) nx = ST_EXPSIGN;
					else if (is_dec(c))              nx = ST_EXPDIG;
					else                             nx = ST_REJECT;
				end
				default: begin
					nx = ST_REJECT;
				end
			endcase
		end
		return nx;
	endfunction

endpackage

// ===== rtl/nlc_in_reg.sv =====
module nlc_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     char_code,
	input  logic           last,
	input  logic           take,
	output logic           in_ready,
	output nlc_pkg::item_t item_s1
);
	import nlc_pkg::*;

	assign in_ready = !item_s1.valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_valid && in_ready) begin
			item_s1 <= '{valid: 1'b1, char_code: char_code, last: last};
		end else if (take) begin
			item_s1.valid <= 1'b0;
		end
	end

endmodule

// ===== rtl/nlc_scanner.sv =====
module nlc_scanner (
	input  logic             clk,
	input  logic             arst_n,
	input  nlc_pkg::item_t   item_s1,
	input  logic             take,
	output nlc_pkg::verdict_t verdict_nx
);
	import nlc_pkg::*;

	scan_state_t state_q;
	scan_state_t state_nx;

	always_comb begin
		state_nx   = advance(state_q, item_s1.char_code);
		verdict_nx = verdict_of(state_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else if (take) begin
			state_q <= item_s1.last ? ST_START : state_nx;
		end
	end

endmodule

// ===== rtl/numeric_literal_classifier.sv =====
// the verdict is registered and out_valid set when the item marked last is taken from stage 1
// throughput: one item per cycle while input is not stalled, set by the scan state update
// a held verdict stalls input only when the next last item reaches stage 1
// reset: arst_n clears the stage and result valids and returns the scanner
// to the start of a token
module numeric_literal_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] verdict
);
	import nlc_pkg::*;

	item_t    item_s1;
	logic     take;
	verdict_t verdict_nx;
	verdict_t verdict_q;
	logic     out_valid_q;

	assign take = item_s1.valid && (!item_s1.last || !out_valid_q || out_ready);

	nlc_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.char_code (char_code),
		.last      (last),
		.take      (take),
		.in_ready  (in_ready),
		.item_s1   (item_s1)
	);

	nlc_scanner u_scanner (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_s1    (item_s1),
		.take       (take),
		.verdict_nx (verdict_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			verdict_q <= verdict_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

// ===== rtl/nlc_checker.sv =====
module nlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] char_code,
	input logic       last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] verdict
);
	import nlc_pkg::*;

	// input stalls only behind a result that is not taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// a waiting item keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(char_code) && $stable(last)))
		else $error("input item dropped or changed while waiting");

	// a held result keeps its verdict
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(verdict)))
		else $error("result dropped or changed while stalled");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict != 2'd3))
		else $error("undefined verdict code");

	// no result can appear unless an item was in flight in the previous cycle
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !in_valid && in_ready) |=> ##1 !$rose(out_valid) || $past(in_valid, 1))
		else $error("result without an item");

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.char_code (char_code),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.verdict   (verdict)
);

// ===== dv/tb_numeric_literal_classifier.sv =====
`timescale 1ns / 1ps

module tb_numeric_literal_classifier;
	import nlc_pkg::*;

	typedef logic [7:0] byte_list_t[$];

	localparam int IDLE_LIMIT = 2000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_code;
	logic       last;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] verdict;

	verdict_t    pending_verdicts[$];
	scan_state_t scan_st = ST_START;
	bit          steady_flow = 1'b0;
	int          sent_chars = 0;
	int          mismatch_count = 0;
	int          idle_cycles = 0;

	numeric_literal_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	always #10 clk = ~clk;

	function automatic verdict_t verdict_for(input scan_state_t s);
		verdict_t v;
		v = VERDICT_NONE;
		if (s == ST_ZERO || s == ST_HEX || s == ST_INTDIG || s == ST_END_INT) begin
			v = VERDICT_INT;
		end else if (s == ST_FRAC || s == ST_EXPDIG || s == ST_END_FLOAT) begin
			v = VERDICT_FLOAT;
		end
		return v;
	endfunction

	function automatic scan_state_t scan_next(input scan_state_t s, input logic [7:0] ch);
		logic        dec;
		logic        hex;
		logic        sgn;
		scan_state_t nx;
		dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
		hex = dec || ((ch >= CH_LC_A) && (ch <= CH_LC_F)) || ((ch >= CH_UC_A) && (ch <= CH_UC_F));
		sgn = (ch == CH_PLUS) || (ch == CH_MINUS);
		nx = ST_REJECT;
		if (s == ST_END_NONE || s == ST_END_INT || s == ST_END_FLOAT) begin
			nx = s;
		end else if (ch == CH_NUL) begin
			case (verdict_for(s))
				VERDICT_INT:   nx = ST_END_INT;
				VERDICT_FLOAT: nx = ST_END_FLOAT;
				default:       nx = ST_END_NONE;
			endcase
		end else begin
			case (s)
				ST_START: begin
					if (sgn)                nx = ST_SIGNED;
					else if (ch == CH_ZERO) nx = ST_ZERO;
					else if (dec)           nx = ST_INTDIG;
				end
				ST_SIGNED: begin
					if (ch == CH_ZERO) nx = ST_ZERO;
					else if (dec)      nx = ST_INTDIG;
				end
				ST_ZERO: begin
					if (ch == CH_LC_X || ch == CH_UC_X) nx = ST_HEX;
					else if (dec)                      nx = ST_INTDIG;
					else if (ch == CH_POINT)           nx = ST_FRAC;
				end
				ST_INTDIG: begin
					if (dec)                 nx = ST_INTDIG;
					else if (ch == CH_POINT) nx = ST_FRAC;
				end
				ST_HEX: begin
					if (hex) nx = ST_HEX;
				end
				ST_FRAC: begin
					if (dec)                                nx = ST_FRAC;
					else if (ch == CH_LC_E || ch == CH_UC_E) nx = ST_EXP;
				end
				ST_EXP: begin
					if (sgn)      nx = ST_EXPSIGN;
					else if (dec) nx = ST_EXPDIG;
				end
				ST_EXPSIGN, ST_EXPDIG: begin
					if (dec) nx = ST_EXPDIG;
				end
				default: begin
					nx = ST_REJECT;
				end
			endcase
		end
		return nx;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic byte_list_t wellformed_token();
		byte_list_t t;
		string      hex_digits;
		int         n;
		hex_digits = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 1)) t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		case ($urandom_range(0, 2))
			0: begin
				n = $urandom_range(1, 5);
				repeat (n) t.push_back(rand_digit());
			end
			1: begin
				t.push_back(CH_ZERO);
				t.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
				n = $urandom_range(0, 5);
				repeat (n) t.push_back(hex_digits[$urandom_range(0, 21)]);
			end
			default: begin
				n = $urandom_range(1, 3);
				repeat (n) t.push_back(rand_digit());
				t.push_back(CH_POINT);
				n = $urandom_range(0, 3);
				repeat (n) t.push_back(rand_digit());
				if ($urandom_range(0, 1)) begin
					t.push_back($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
					if ($urandom_range(0, 1)) t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
					n = $urandom_range(1, 3);
					repeat (n) t.push_back(rand_digit());
				end
			end
		endcase
		return t;
	endfunction

	function automatic byte_list_t malformed_token();
		byte_list_t t;
		string      grammar_chars;
		int         n;
		grammar_chars = "+-.eExX0z";
		case ($urandom_range(0, 3))
			0: begin
				n = $urandom_range(1, 6);
				repeat (n) t.push_back(8'($urandom_range(0, 255)));
			end
			1: begin
				t = wellformed_token();
				t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
			end
			2: begin
				t = wellformed_token();
				t.insert($urandom_range(0, t.size()), CH_NUL);
				n = $urandom_range(0, 3);
				repeat (n) t.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				t = wellformed_token();
				n = $urandom_range(1, 2);
				repeat (n) t.push_back(grammar_chars[$urandom_range(0, 8)]);
			end
		endcase
		return t;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic fin);
		int          gap;
		scan_state_t nx;
		gap = steady_flow ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= ch;
		last      <= fin;
		do @(posedge clk); while (!in_ready);
		nx = scan_next(scan_st, ch);
		if (fin) begin
			pending_verdicts.push_back(verdict_for(nx));
			scan_st = ST_START;
		end else begin
			scan_st = nx;
		end
		sent_chars++;
	endtask

	task automatic send_token(input byte_list_t t);
		for (int i = 0; i < t.size(); i++) begin
			send_char(t[i], i == t.size() - 1);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	task automatic test_directed();
		send_char(CH_NUL, 1'b1);
		send_text("+");
		send_text("0x");
		send_text("9");
		send_text("-0XaF");
		send_text("1.e-9");
		send_text("2.");
		send_text("1e5");
		send_char(CH_NINE, 1'b0);
		send_char(8'hff, 1'b1);
		// zero byte then ignored tail
		send_char(CH_ZERO + 8'd5, 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char(8'h7a, 1'b1);
		send_char(CH_ZERO + 8'd3, 1'b0);
		send_char(CH_NUL, 1'b1);
	endtask

	task automatic test_wellformed(input int budget);
		int stop_at;
		stop_at = sent_chars + budget;
		while (sent_chars < stop_at) begin
			steady_flow = ($urandom_range(0, 9) == 0);
			send_token(wellformed_token());
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_malformed(input int budget);
		int stop_at;
		stop_at = sent_chars + budget;
		while (sent_chars < stop_at) begin
			steady_flow = ($urandom_range(0, 9) == 0);
			send_token(malformed_token());
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_back_to_back(input int budget);
		int stop_at;
		stop_at = sent_chars + budget;
		steady_flow = 1'b1;
		while (sent_chars < stop_at) begin
			send_token($urandom_range(0, 2) ? wellformed_token() : malformed_token());
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected item: verdict %0d", verdict);
				mismatch_count++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (verdict !== exp_v) begin
					$error("verdict mismatch: expected %0d actual %0d", exp_v, verdict);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("numeric_literal_classifier test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_code = 8'h00;
		last      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_wellformed(500);
		test_malformed(350);
		test_back_to_back(175);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("numeric_literal_classifier test passed");
		end else begin
			$display("numeric_literal_classifier test failed");
		end
		$finish;
	end

endmodule
